@@ sv/ouart_pkg.sv @@
package ouart_pkg;

  // request kinds carried in s_tuser
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_FLUSH = 2'd3
  } opcode_t;

  // configuration register indexes
  localparam logic [1:0] REG_RX_DATA_BITS  = 2'd0;
  localparam logic [1:0] REG_TX_FRAME_BITS = 2'd1;
  localparam logic [1:0] REG_DROP_BYTE     = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // reset values of the configuration registers
  localparam logic [3:0] RX_DATA_BITS_RST  = 4'd8;
  localparam logic [3:0] TX_FRAME_BITS_RST = 4'd10;
  localparam logic [7:0] DROP_BYTE_RST     = 8'hC2;

  // tick counts at three times the baud rate
  localparam logic [1:0] TX_BIT_TICKS    = 2'd3;
  localparam logic [2:0] RX_BIT_TICKS    = 3'd3;
  localparam logic [2:0] RX_FIRST_TICKS  = 3'd4;
  localparam logic [3:0] RX_INDEX_MAX    = 4'd15;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

endpackage

@@ sv/ouart_ram.sv @@
module ouart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/oversampled_uart_with_rx_fifo_unit.sv @@
// channel  | dir | handshake         | payload
// ---------+-----+-------------------+---------------------------------------------
// s        | in  | s_tvalid/s_tready | s_tuser opcode, s_tdata rx_pin, tx_byte
// m        | out | m_tvalid/m_tready | m_tdata tx_pin, rx_byte, flags
// cfg      | in  | cfg_we            | cfg_index, cfg_data
//
// one request is taken per cycle while no result is stalled; its result shows on m in the cycle after
// all request state updates happen at the accept edge; a read pulls the ring entry
// through the ram's registered read port at that same edge
// a stalled result holds the output register and s_tready drops until the
// result is taken; s_tready rises again in the cycle the result leaves
// rst is synchronous; ring contents are not cleared, only the pointers
module oversampled_uart_with_rx_fifo_unit #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [0] rx_pin, [8:1] tx_byte, [15:9] zero
  input  logic [ouart_pkg::IN_DATA_W-1:0]    s_tdata,
  // [1:0] opcode
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] tx_pin, [8:1] rx_byte, [9] rx_valid, [10] tx_accepted,
  // [11] rx_available, [12] tx_busy, [15:13] zero
  output logic [ouart_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                               cfg_we,
  input  logic [ouart_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ouart_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import ouart_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // configuration
  logic [3:0] rx_data_bits;
  logic [3:0] tx_frame_bits;
  logic [7:0] drop_byte;

  // ring pointers
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;

  // transmitter
  logic [9:0] tx_shift, tx_shift_next;
  logic [1:0] tx_tick_count, tx_tick_count_next;
  logic [3:0] tx_bits_left, tx_bits_left_next;
  logic       tx_active, tx_active_next;
  logic       tx_line, tx_line_next;

  // receiver
  logic [7:0] rx_shift, rx_shift_next;
  logic [2:0] rx_tick_count, rx_tick_count_next;
  logic [3:0] rx_bit_index, rx_bit_index_next;
  logic       rx_active, rx_active_next;
  logic       rx_stop_wait, rx_stop_wait_next;

  // output register
  logic       out_tx_pin, out_rx_valid, out_tx_accepted, out_rx_available, out_tx_busy;
  logic       rx_valid_next, tx_accepted_next;
  logic [7:0] ram_rdata;

  logic       accept;
  opcode_t    op;
  logic       pin;
  logic [7:0] byte_in;
  logic       push;
  logic       pop;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = opcode_t'(s_tuser);
  assign pin      = s_tdata[0];
  assign byte_in  = s_tdata[8:1];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // configuration writes, indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_data_bits  <= RX_DATA_BITS_RST;
      tx_frame_bits <= TX_FRAME_BITS_RST;
      drop_byte     <= DROP_BYTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RX_DATA_BITS:  rx_data_bits  <= cfg_data[3:0];
        REG_TX_FRAME_BITS: tx_frame_bits <= cfg_data[3:0];
        REG_DROP_BYTE:     drop_byte     <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state for one request
  always_comb begin
    wr_ptr_next        = wr_ptr;
    rd_ptr_next        = rd_ptr;
    tx_shift_next      = tx_shift;
    tx_tick_count_next = tx_tick_count;
    tx_bits_left_next  = tx_bits_left;
    tx_active_next     = tx_active;
    tx_line_next       = tx_line;
    rx_shift_next      = rx_shift;
    rx_tick_count_next = rx_tick_count;
    rx_bit_index_next  = rx_bit_index;
    rx_active_next     = rx_active;
    rx_stop_wait_next  = rx_stop_wait;
    rx_valid_next      = 1'b0;
    tx_accepted_next   = 1'b0;
    push               = 1'b0;
    pop                = 1'b0;

    unique case (op)
      OP_TICK: begin
        // transmit side: one line bit every three ticks
        if (tx_active) begin
          if (tx_tick_count > 2'd1) begin
            tx_tick_count_next = tx_tick_count - 2'd1;
          end else begin
            tx_line_next       = tx_shift[0];
            tx_shift_next      = {1'b1, tx_shift[9:1]};
            tx_tick_count_next = TX_BIT_TICKS;
            if (tx_bits_left <= 4'd1) begin
              tx_bits_left_next = 4'd0;
              tx_active_next    = 1'b0;
            end else begin
              tx_bits_left_next = tx_bits_left - 4'd1;
            end
          end
        end

        // receive side
        if (rx_stop_wait) begin
          if (rx_tick_count > 3'd1) begin
            rx_tick_count_next = rx_tick_count - 3'd1;
          end else begin
            rx_tick_count_next = 3'd0;
            rx_stop_wait_next  = 1'b0;
            rx_active_next     = 1'b0;
            if (rx_shift != drop_byte) begin
              push        = 1'b1;
              wr_ptr_next = ptr_inc(wr_ptr);
            end
          end
        end else if (!rx_active) begin
          // hunting a low start bit
          if (!pin) begin
            rx_active_next     = 1'b1;
            rx_shift_next      = 8'd0;
            rx_tick_count_next = RX_FIRST_TICKS;
            rx_bit_index_next  = 4'd0;
          end
        end else if (rx_tick_count > 3'd1) begin
          rx_tick_count_next = rx_tick_count - 3'd1;
        end else begin
          rx_tick_count_next = RX_BIT_TICKS;
          // bits past the eighth are sampled but dropped
          if (pin && !rx_bit_index[3]) begin
            rx_shift_next[rx_bit_index[2:0]] = 1'b1;
          end
          if (rx_bit_index < RX_INDEX_MAX) begin
            rx_bit_index_next = rx_bit_index + 4'd1;
          end
          if (rx_bit_index_next >= rx_data_bits) begin
            rx_stop_wait_next = 1'b1;
          end
        end
      end
      OP_WRITE: begin
        if (!tx_active) begin
          tx_tick_count_next = TX_BIT_TICKS;
          tx_bits_left_next  = tx_frame_bits;
          tx_shift_next      = {1'b1, byte_in, 1'b0};
          tx_active_next     = 1'b1;
          tx_accepted_next   = 1'b1;
        end
      end
      OP_READ: begin
        if (rd_ptr != wr_ptr) begin
          pop           = 1'b1;
          rd_ptr_next   = ptr_inc(rd_ptr);
          rx_valid_next = 1'b1;
        end
      end
      OP_FLUSH: begin
        wr_ptr_next = '0;
        rd_ptr_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      tx_shift      <= '0;
      tx_tick_count <= '0;
      tx_bits_left  <= '0;
      tx_active     <= 1'b0;
      tx_line       <= 1'b0;
      rx_shift      <= '0;
      rx_tick_count <= '0;
      rx_bit_index  <= '0;
      rx_active     <= 1'b0;
      rx_stop_wait  <= 1'b0;
    end else if (accept) begin
      wr_ptr        <= wr_ptr_next;
      rd_ptr        <= rd_ptr_next;
      tx_shift      <= tx_shift_next;
      tx_tick_count <= tx_tick_count_next;
      tx_bits_left  <= tx_bits_left_next;
      tx_active     <= tx_active_next;
      tx_line       <= tx_line_next;
      rx_shift      <= rx_shift_next;
      rx_tick_count <= rx_tick_count_next;
      rx_bit_index  <= rx_bit_index_next;
      rx_active     <= rx_active_next;
      rx_stop_wait  <= rx_stop_wait_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tx_pin       <= tx_line_next;
      out_rx_valid     <= rx_valid_next;
      out_tx_accepted  <= tx_accepted_next;
      out_rx_available <= (rd_ptr_next != wr_ptr_next);
      out_tx_busy      <= tx_active_next;
    end
  end

  // receive ring, read data lands beside the result register
  ouart_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (accept && push),
    .waddr (wr_ptr),
    .wdata (rx_shift),
    .re    (accept && pop),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  assign m_tdata = {3'd0, out_tx_busy, out_rx_available, out_tx_accepted, out_rx_valid,
                    (out_rx_valid ? ram_rdata : 8'd0), out_tx_pin};

`ifndef NO_ASSERTIONS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_rx_valid && out_tx_accepted))
    else $error("read and write flags both set");

  a_tx_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !tx_active |-> (tx_bits_left == 4'd0))
    else $error("idle transmitter with bits left");

  a_stop_in_frame: assert property (@(posedge clk) disable iff (rst)
    rx_stop_wait |-> rx_active)
    else $error("stop wait outside a receive frame");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_FLUSH)) |=> ((wr_ptr == '0) && (rd_ptr == '0)))
    else $error("flush left pointers set");

  a_rx_count_range: assert property (@(posedge clk) disable iff (rst)
    rx_tick_count <= RX_FIRST_TICKS)
    else $error("receive tick count out of range");
`endif

endmodule
